>>> hw/rtl/lagi_pkg.sv
// ----------------------------------------------------------------------------
// lagi_pkg: shared types and widths for the Lagrange interpolator
// Field widths, datapath widths and the control bundle that rides the pipe.
// ----------------------------------------------------------------------------
package lagi_pkg;

    localparam int X_W    = 24;           // abscissa width, integer ticks
    localparam int Y_W    = 32;           // node value width, unsigned fixed point
    localparam int V_W    = 32;           // result width, signed fixed point
    localparam int NODES  = 4;            // node slots per request
    localparam int FACS   = NODES - 1;    // factors per term
    localparam int P_W    = 2 * X_W;      // product of two differences
    localparam int R_W    = Y_W + X_W;    // value times one difference
    localparam int RL_W   = R_W / 2;      // low half of R for partial products
    localparam int RH_W   = R_W - RL_W;
    localparam int PP_W   = X_W + RL_W;   // partial product width
    localparam int NUM_W  = Y_W + 3 * X_W;// numerator width
    localparam int DEN_W  = 3 * X_W;      // denominator width
    localparam int DVD_W  = NUM_W + 2;    // dividend 2*num + den
    localparam int DVS_W  = DEN_W + 1;    // divisor 2*den
    localparam int T_W    = DVD_W + 4;    // signed term and sum width

    typedef logic [X_W-1:0] x_t;
    typedef logic [Y_W-1:0] y_t;

    // Control that travels beside every data stage.
    typedef struct packed {
        logic             valid;
        logic             dup;
        logic [NODES-1:0] neg;
    } ctl_t;

    // Factor slot of node j inside the product for term i (j != i).
    function automatic logic [1:0] slot(input logic [1:0] i, input logic [1:0] j);
        logic [1:0] s;
        s = (j < i) ? j : j - 2'd1;
        return s;
    endfunction

endpackage

>>> hw/rtl/lagi_if.sv
// ----------------------------------------------------------------------------
// lagi_if: request and result channels of the Lagrange interpolator
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface lagi_query_if;
    logic                valid;
    logic                ready;
    logic                kind;
    lagi_pkg::x_t        query_x;
    lagi_pkg::x_t        node_x_a;
    lagi_pkg::x_t        node_x_b;
    lagi_pkg::x_t        node_x_c;
    lagi_pkg::x_t        node_x_d;
    lagi_pkg::y_t        node_y_a;
    lagi_pkg::y_t        node_y_b;
    lagi_pkg::y_t        node_y_c;
    lagi_pkg::y_t        node_y_d;

    modport source (output valid, kind, query_x, node_x_a, node_x_b, node_x_c,
                    node_x_d, node_y_a, node_y_b, node_y_c, node_y_d,
                    input ready);
    modport sink   (input valid, kind, query_x, node_x_a, node_x_b, node_x_c,
                    node_x_d, node_y_a, node_y_b, node_y_c, node_y_d,
                    output ready);
endinterface

interface lagi_result_if;
    logic                        valid;
    logic                        ready;
    logic signed [lagi_pkg::V_W-1:0] interp_value;
    logic                        error_flag;

    modport source (output valid, interp_value, error_flag, input ready);
    modport sink   (input valid, interp_value, error_flag, output ready);
endinterface

>>> hw/rtl/lagrange_interpolator.sv
// ----------------------------------------------------------------------------
// lagrange_interpolator: cubic or quadratic Lagrange interpolation
// Evaluates the interpolating polynomial through three or four nodes at a
// query abscissa, with per-term round-to-nearest and saturation of the sum.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------------------------------
//  query    | in  | kind, query_x, node_x_a..d, node_y_a..d
//  result   | out | interp_value, error_flag
//
// One request enters per clock cycle while the pipeline is not held. A
// request passes 115 register stages: the input register, five arithmetic
// stages before the divider, a 106-stage divider that settles one quotient
// bit per stage (the dividend width sets its length), a signing stage, a
// summing stage and the output register. Reset clears the control that
// travels with each request; data registers keep their contents. The whole
// pipeline moves as one: it holds while a finished result waits and
// result.ready is low, so nothing is dropped or repeated; a held result
// leaves the output register unchanged.
//
// Each term is y_i * prod(q - x_j) / prod(x_i - x_j), built from magnitudes
// with the sign carried separately. The ratio has no dimension, so the
// number of fraction bits in the values does not change the arithmetic.
// In quadratic mode the fourth node becomes a term of value zero and the
// factors that involve it become one.
module lagrange_interpolator (
    input  logic                 clk,
    input  logic                 rst_n,
    lagi_query_if.sink           query,
    lagi_result_if.source        result
);

    localparam int N   = lagi_pkg::NODES;
    localparam int F   = lagi_pkg::FACS;
    localparam int DIV = lagi_pkg::DVD_W;

    logic adv;

    // The pipeline advances whenever the output register is free or drained.
    assign adv         = !result.valid || result.ready;
    assign query.ready = adv;

    // ---------------------------------------------------------------- stage 1
    logic          v1_reg;
    logic          kind1_reg;
    lagi_pkg::x_t  q1_reg;
    lagi_pkg::x_t  x1_reg [N];
    lagi_pkg::y_t  y1_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= query.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind1_reg <= query.kind;
            q1_reg    <= query.query_x;
            x1_reg[0] <= query.node_x_a;
            x1_reg[1] <= query.node_x_b;
            x1_reg[2] <= query.node_x_c;
            x1_reg[3] <= query.node_x_d;
            y1_reg[0] <= query.node_y_a;
            y1_reg[1] <= query.node_y_b;
            y1_reg[2] <= query.node_y_c;
            y1_reg[3] <= query.node_y_d;
        end
    end

    // ---------------------------------------------------------------- stage 2
    // Differences, their magnitudes and signs, factor selection per term.
    lagi_pkg::x_t  fn_next [N][F];
    lagi_pkg::x_t  fd_next [N][F];
    lagi_pkg::y_t  y2_next [N];
    lagi_pkg::ctl_t c2_next;
    lagi_pkg::x_t  fn2_reg [N][F];
    lagi_pkg::x_t  fd2_reg [N][F];
    lagi_pkg::y_t  y2_reg  [N];
    lagi_pkg::ctl_t c2_reg;

    always_comb
    begin
        logic [lagi_pkg::X_W:0] dq;
        logic [lagi_pkg::X_W:0] dd;
        lagi_pkg::x_t           qm [N];
        logic [N-1:0]           qs;
        lagi_pkg::x_t           dm;
        logic                   ds;
        logic                   use_j;
        logic [1:0]             k;

        dd    = '0;
        dm    = '0;
        ds    = 1'b0;
        use_j = 1'b0;
        k     = '0;

        for (int j = 0; j < N; j++)
        begin
            dq    = {1'b0, q1_reg} - {1'b0, x1_reg[j]};
            qs[j] = dq[lagi_pkg::X_W];
            qm[j] = qs[j] ? lagi_pkg::X_W'(-dq) : dq[lagi_pkg::X_W-1:0];
        end

        c2_next.valid = v1_reg;
        c2_next.dup   = (x1_reg[0] == x1_reg[1]) || (x1_reg[0] == x1_reg[2])
                     || (x1_reg[1] == x1_reg[2])
                     || (kind1_reg && ((x1_reg[3] == x1_reg[0])
                                    || (x1_reg[3] == x1_reg[1])
                                    || (x1_reg[3] == x1_reg[2])));

        for (int i = 0; i < N; i++)
        begin
            c2_next.neg[i] = 1'b0;
            y2_next[i]     = (i == N - 1 && !kind1_reg) ? '0 : y1_reg[i];
            for (int f = 0; f < F; f++)
            begin
                fn_next[i][f] = lagi_pkg::X_W'(1);
                fd_next[i][f] = lagi_pkg::X_W'(1);
            end
            for (int j = 0; j < N; j++)
            begin
                if (j != i)
                begin
                    dd    = {1'b0, x1_reg[i]} - {1'b0, x1_reg[j]};
                    ds    = dd[lagi_pkg::X_W];
                    dm    = ds ? lagi_pkg::X_W'(-dd) : dd[lagi_pkg::X_W-1:0];
                    use_j = kind1_reg || (i != N - 1 && j != N - 1);
                    k     = lagi_pkg::slot(2'(i), 2'(j));
                    if (use_j)
                    begin
                        fn_next[i][k]  = qm[j];
                        fd_next[i][k]  = dm;
                        c2_next.neg[i] = c2_next.neg[i] ^ qs[j] ^ ds;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic [lagi_pkg::P_W-1:0] pa3_reg [N];
    logic [lagi_pkg::R_W-1:0] ra3_reg [N];
    logic [lagi_pkg::P_W-1:0] da3_reg [N];
    lagi_pkg::x_t             fd3_reg [N];
    lagi_pkg::ctl_t           c3_reg;

    // ---------------------------------------------------------------- stage 4
    // Partial products of the wide numerator and denominator multiplies.
    logic [lagi_pkg::PP_W-1:0] pll4_reg [N];
    logic [lagi_pkg::PP_W-1:0] plh4_reg [N];
    logic [lagi_pkg::PP_W-1:0] phl4_reg [N];
    logic [lagi_pkg::PP_W-1:0] phh4_reg [N];
    logic [lagi_pkg::P_W-1:0]  dl4_reg  [N];
    logic [lagi_pkg::P_W-1:0]  dh4_reg  [N];
    lagi_pkg::ctl_t            c4_reg;

    // ---------------------------------------------------------------- stage 5
    logic [lagi_pkg::NUM_W-1:0] num5_reg [N];
    logic [lagi_pkg::DEN_W-1:0] den5_reg [N];
    lagi_pkg::ctl_t             c5_reg;

    // ---------------------------------------------------------------- stage 6
    // Rounded quotient: floor((2 num + den) / (2 den)).
    logic [lagi_pkg::DVD_W-1:0] nn6_reg [N];
    logic [lagi_pkg::DVS_W-1:0] dd6_reg [N];
    lagi_pkg::ctl_t             c6_reg;

    // Control that walks beside the divider stages.
    lagi_pkg::ctl_t             cd_reg [DIV];
    logic [lagi_pkg::DVD_W-1:0] quo [N];

    // ---------------------------------------------------------------- stages 7..9
    logic signed [lagi_pkg::T_W-1:0] t7_reg [N];
    lagi_pkg::ctl_t                  c7_reg;
    logic signed [lagi_pkg::T_W-1:0] p8_reg [2];
    lagi_pkg::ctl_t                  c8_reg;

    logic signed [lagi_pkg::T_W-1:0] sum9;
    logic signed [lagi_pkg::V_W-1:0] value_next;
    logic                            err_next;
    logic                            out_valid_reg;
    logic signed [lagi_pkg::V_W-1:0] out_value_reg;
    logic                            out_err_reg;

    // Control bundles: reset clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_reg        <= '0;
            c3_reg        <= '0;
            c4_reg        <= '0;
            c5_reg        <= '0;
            c6_reg        <= '0;
            c7_reg        <= '0;
            c8_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < DIV; s++)
            begin
                cd_reg[s] <= '0;
            end
        end
        else if (adv)
        begin
            c2_reg    <= c2_next;
            c3_reg    <= c2_reg;
            c4_reg    <= c3_reg;
            c5_reg    <= c4_reg;
            c6_reg    <= c5_reg;
            cd_reg[0] <= c6_reg;
            for (int s = 1; s < DIV; s++)
            begin
                cd_reg[s] <= cd_reg[s-1];
            end
            c7_reg        <= cd_reg[DIV-1];
            c8_reg        <= c7_reg;
            out_valid_reg <= c8_reg.valid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fn2_reg    <= fn_next;
            fd2_reg    <= fd_next;
            y2_reg     <= y2_next;

            for (int i = 0; i < N; i++)
            begin
                pa3_reg[i] <= fn2_reg[i][0] * fn2_reg[i][1];
                ra3_reg[i] <= y2_reg[i] * fn2_reg[i][2];
                da3_reg[i] <= fd2_reg[i][0] * fd2_reg[i][1];
                fd3_reg[i] <= fd2_reg[i][2];

                pll4_reg[i] <= pa3_reg[i][lagi_pkg::X_W-1:0]
                             * ra3_reg[i][lagi_pkg::RL_W-1:0];
                plh4_reg[i] <= pa3_reg[i][lagi_pkg::X_W-1:0]
                             * ra3_reg[i][lagi_pkg::R_W-1:lagi_pkg::RL_W];
                phl4_reg[i] <= pa3_reg[i][lagi_pkg::P_W-1:lagi_pkg::X_W]
                             * ra3_reg[i][lagi_pkg::RL_W-1:0];
                phh4_reg[i] <= pa3_reg[i][lagi_pkg::P_W-1:lagi_pkg::X_W]
                             * ra3_reg[i][lagi_pkg::R_W-1:lagi_pkg::RL_W];
                dl4_reg[i]  <= da3_reg[i][lagi_pkg::X_W-1:0] * fd3_reg[i];
                dh4_reg[i]  <= da3_reg[i][lagi_pkg::P_W-1:lagi_pkg::X_W] * fd3_reg[i];

                num5_reg[i] <= lagi_pkg::NUM_W'(pll4_reg[i])
                             + (lagi_pkg::NUM_W'(plh4_reg[i]) << lagi_pkg::RL_W)
                             + (lagi_pkg::NUM_W'(phl4_reg[i]) << lagi_pkg::X_W)
                             + (lagi_pkg::NUM_W'(phh4_reg[i])
                                << (lagi_pkg::X_W + lagi_pkg::RL_W));
                den5_reg[i] <= lagi_pkg::DEN_W'(dl4_reg[i])
                             + (lagi_pkg::DEN_W'(dh4_reg[i]) << lagi_pkg::X_W);

                nn6_reg[i]  <= {1'b0, num5_reg[i], 1'b0}
                             + lagi_pkg::DVD_W'(den5_reg[i]);
                dd6_reg[i]  <= {den5_reg[i], 1'b0};

                t7_reg[i]   <= cd_reg[DIV-1].neg[i]
                             ? -$signed(lagi_pkg::T_W'(quo[i]))
                             :  $signed(lagi_pkg::T_W'(quo[i]));
            end
            p8_reg[0] <= t7_reg[0] + t7_reg[1];
            p8_reg[1] <= t7_reg[2] + t7_reg[3];
            out_value_reg <= value_next;
            out_err_reg   <= err_next;
        end
    end

    // Per-term dividers.
    for (genvar i = 0; i < N; i++) begin : g_term
        lagi_div #(
            .NUM_W (lagi_pkg::DVD_W),
            .DIV_W (lagi_pkg::DVS_W)
        ) u_div (
            .clk      (clk),
            .en       (adv),
            .dividend (nn6_reg[i]),
            .divisor  (dd6_reg[i]),
            .quotient (quo[i])
        );
    end

    // Final sum and saturation into signed result range; duplicate nodes give zero with the error flag.
    always_comb
    begin
        sum9 = p8_reg[0] + p8_reg[1];
        if (c8_reg.dup)
        begin
            value_next = '0;
            err_next   = 1'b1;
        end
        else if ((&sum9[lagi_pkg::T_W-1:lagi_pkg::V_W-1])
              || !(|sum9[lagi_pkg::T_W-1:lagi_pkg::V_W-1]))
        begin
            value_next = sum9[lagi_pkg::V_W-1:0];
            err_next   = 1'b0;
        end
        else if (sum9[lagi_pkg::T_W-1])
        begin
            value_next = {1'b1, {(lagi_pkg::V_W-1){1'b0}}};
            err_next   = 1'b1;
        end
        else
        begin
            value_next = {1'b0, {(lagi_pkg::V_W-1){1'b1}}};
            err_next   = 1'b1;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.interp_value = out_value_reg;
    assign result.error_flag   = out_err_reg;

    // A waiting result must hold the whole pipeline, so no request enters.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !query.ready)
        else $error("request accepted while a result is held");

    // An error with a nonzero value can only be a saturated sum.
    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.error_flag && result.interp_value != '0)
        |-> (result.interp_value == $signed({1'b0, {(lagi_pkg::V_W-1){1'b1}}})
          || result.interp_value == $signed({1'b1, {(lagi_pkg::V_W-1){1'b0}}})))
        else $error("error result is neither zero nor a saturation limit");

    // A result leaving the output register was in the last sum stage before.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(result.valid)) |-> $past(c8_reg.valid))
        else $error("result appeared without a request behind it");

endmodule

>>> hw/rtl/lagi_div.sv
// ----------------------------------------------------------------------------
// lagi_div: pipelined restoring divider
// One quotient bit per stage; all stages advance together on en.
// ----------------------------------------------------------------------------
module lagi_div #(
    parameter int NUM_W = lagi_pkg::DVD_W,
    parameter int DIV_W = lagi_pkg::DVS_W
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient
);

    localparam int W = DIV_W + NUM_W;

    logic [W-1:0]     w_reg [NUM_W];
    logic [DIV_W-1:0] d_reg [NUM_W];
    logic [W-1:0]     w_src [NUM_W];
    logic [DIV_W-1:0] d_src [NUM_W];
    logic [W-1:0]     w_next [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_step
        logic [W:0]       sh;
        logic [DIV_W:0]   top;
        logic [DIV_W:0]   diff;
        logic             ge;

        if (s == 0) begin : g_first
            assign w_src[s] = {{DIV_W{1'b0}}, dividend};
            assign d_src[s] = divisor;
        end
        else begin : g_rest
            assign w_src[s] = w_reg[s-1];
            assign d_src[s] = d_reg[s-1];
        end

        // Shift in the next dividend bit, then subtract if the divisor fits.
        always_comb
        begin
            sh   = {w_src[s], 1'b0};
            top  = sh[W:NUM_W];
            diff = top - {1'b0, d_src[s]};
            ge   = (top >= {1'b0, d_src[s]});
            if (ge)
            begin
                w_next[s] = {diff[DIV_W-1:0], sh[NUM_W-1:1], 1'b1};
            end
            else
            begin
                w_next[s] = {top[DIV_W-1:0], sh[NUM_W-1:0]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                w_reg[s] <= w_next[s];
                d_reg[s] <= d_src[s];
            end
        end
    end

    assign quotient = w_reg[NUM_W-1][NUM_W-1:0];

endmodule
